### sv/u8sd_pkg.sv
package u8sd_pkg;

   localparam int unsigned ByteWidth  = 8;
   localparam int unsigned PointWidth = 21;
   localparam int unsigned PendWidth  = 2;

   localparam logic [PointWidth-1:0] ReplacementChar = 21'h00FFFD;

   localparam logic [2:0] Lead2Code = 3'h6;
   localparam logic [3:0] Lead3Code = 4'hE;
   localparam logic [4:0] Lead4Code = 5'h1E;

   localparam logic [PendWidth-1:0] PendNone  = 2'd0;
   localparam logic [PendWidth-1:0] PendOne   = 2'd1;
   localparam logic [PendWidth-1:0] PendTwo   = 2'd2;
   localparam logic [PendWidth-1:0] PendThree = 2'd3;

   typedef struct packed {
      logic [ByteWidth-1:0] data_byte;
      logic                 last_byte;
   } in_word_type;

   typedef struct packed {
      logic [PointWidth-1:0] code_point;
      logic                  code_last;
   } out_word_type;

   typedef struct packed {
      logic         emit;
      out_word_type word;
   } dec_result_type;

endpackage

### sv/utf8_stream_decoder.sv
// UTF-8 stream decoder.
// Input channel (req_valid / req_stall / req_data): one byte per word, with
// last_byte set on the final byte of a buffer.
// Result channel (rsp_valid / rsp_stall / rsp_data): one code point per word,
// code_last set on the final code point of a buffer. Invalid lead bytes and
// sequences cut short by the end of the buffer give U+FFFD.
// A byte is held in an input register, decoded against the pending-sequence
// state once the output register is free, and any result lands in the output
// register.
// Throughput is one byte per cycle while the receiver takes results; a held
// result is replaced in the same cycle it is taken.
// Bytes that complete nothing (lead and middle continuation bytes without
// last_byte) produce no result word.
// When the receiver stalls with a result waiting, the input register fills
// and req_stall rises; no byte or result is dropped.
// Reset clears the valid flags and the decoder state; no sequence is open.
module utf8_stream_decoder import u8sd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  in_word_type  req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output out_word_type rsp_data
);

   logic           stage_valid;
   in_word_type    stage_word;
   logic           out_free;
   logic           fire;
   dec_result_type result;

   assign fire = stage_valid && out_free;

   u8sd_in_stage u_in (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .advance     (fire),
      .stage_valid (stage_valid),
      .stage_word  (stage_word)
   );

   u8sd_decode u_dec (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .word   (stage_word),
      .result (result)
   );

   u8sd_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .result    (result),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

### sv/u8sd_in_stage.sv
module u8sd_in_stage import u8sd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  in_word_type req_data,
   input  logic        advance,
   output logic        stage_valid,
   output in_word_type stage_word
);

   logic        valid_ff, valid_in;
   in_word_type word_ff;
   logic        take;

   assign req_stall = valid_ff && !advance;
   assign take      = req_valid && !req_stall;
   assign valid_in  = take || (valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         word_ff <= req_data;
      end
   end

   assign stage_valid = valid_ff;
   assign stage_word  = word_ff;

endmodule

### sv/u8sd_decode.sv
module u8sd_decode import u8sd_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           fire,
   input  in_word_type    word,
   output dec_result_type result
);

   logic [PendWidth-1:0]  pend_ff, pend_in;
   logic [PointWidth-1:0] acc_ff, acc_in;
   logic [ByteWidth-1:0]  b;
   logic                  last;
   logic [PointWidth-1:0] shifted;

   assign b       = word.data_byte;
   assign last    = word.last_byte;
   assign shifted = {acc_ff[PointWidth-7:0], b[5:0]};

   always_comb begin
      pend_in                = pend_ff;
      acc_in                 = acc_ff;
      result.emit            = 1'b0;
      result.word.code_point = ReplacementChar;
      result.word.code_last  = last;
      if (pend_ff == PendNone) begin
         if (!b[7]) begin
            result.emit            = 1'b1;
            result.word.code_point = {{(PointWidth-ByteWidth){1'b0}}, b};
         end else if (b[7:5] == Lead2Code || b[7:4] == Lead3Code || b[7:3] == Lead4Code) begin
            if (last) begin
               result.emit = 1'b1;
            end else if (b[7:5] == Lead2Code) begin
               acc_in  = {{(PointWidth-5){1'b0}}, b[4:0]};
               pend_in = PendOne;
            end else if (b[7:4] == Lead3Code) begin
               acc_in  = {{(PointWidth-4){1'b0}}, b[3:0]};
               pend_in = PendTwo;
            end else begin
               acc_in  = {{(PointWidth-3){1'b0}}, b[2:0]};
               pend_in = PendThree;
            end
         end else begin
            result.emit = 1'b1;
         end
      end else begin
         if (pend_ff == PendOne) begin
            result.emit            = 1'b1;
            result.word.code_point = shifted;
            acc_in                 = '0;
            pend_in                = PendNone;
         end else if (last) begin
            result.emit = 1'b1;
            acc_in      = '0;
            pend_in     = PendNone;
         end else begin
            acc_in  = shifted;
            pend_in = pend_ff - PendOne;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= PendNone;
         acc_ff  <= '0;
      end else if (fire) begin
         pend_ff <= pend_in;
         acc_ff  <= acc_in;
      end
   end

`ifndef SYNTHESIS
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      fire && word.last_byte |=> pend_ff == PendNone && acc_ff == '0)
      else $error("state left open after last byte");
   a_idle_acc_zero: assert property (@(posedge clock) disable iff (reset)
      pend_ff == PendNone |-> acc_ff == '0)
      else $error("accumulator nonzero with no sequence open");
   a_acc_bound: assert property (@(posedge clock) disable iff (reset)
      pend_ff == PendThree |-> acc_ff[PointWidth-1:3] == '0)
      else $error("accumulator too wide for four-byte lead");
   a_pending_no_emit: assert property (@(posedge clock) disable iff (reset)
      fire && !word.last_byte && pend_in != PendNone |-> !result.emit)
      else $error("result emitted mid-sequence");
`endif

endmodule

### sv/u8sd_out_stage.sv
module u8sd_out_stage import u8sd_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           fire,
   input  dec_result_type result,
   output logic           out_free,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output out_word_type   rsp_data
);

   logic         valid_ff, valid_in;
   out_word_type word_ff;
   logic         load;

   assign out_free = !valid_ff || !rsp_stall;
   assign load     = fire && result.emit;
   assign valid_in = load || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= result.word;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = word_ff;

endmodule

### sim/utf8_stream_decoder_checker.sv
`timescale 1ns / 1ps

module utf8_stream_decoder_checker import u8sd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_stall,
   input  in_word_type  req_data,
   input  logic         rsp_valid,
   input  logic         rsp_stall,
   input  out_word_type rsp_data,
   output int           error_count,
   output int           awaiting_count
);

   logic [PendWidth-1:0]  bytes_owed;
   logic [PointWidth-1:0] partial_point;
   out_word_type          expected_points[$];

   // returns 1 when the byte closes a code point (or a replacement)
   function automatic bit decode_byte(input in_word_type word, output out_word_type point);
      logic [ByteWidth-1:0] b;
      bit                   produced;
      b                = word.data_byte;
      produced         = 1'b0;
      point.code_point = '0;
      point.code_last  = word.last_byte;
      if (bytes_owed == PendNone) begin
         if (!b[7]) begin
            produced         = 1'b1;
            point.code_point = {{(PointWidth-ByteWidth){1'b0}}, b};
         end else if (b[7:5] == Lead2Code) begin
            partial_point = {16'd0, b[4:0]};
            bytes_owed    = PendOne;
         end else if (b[7:4] == Lead3Code) begin
            partial_point = {17'd0, b[3:0]};
            bytes_owed    = PendTwo;
         end else if (b[7:3] == Lead4Code) begin
            partial_point = {18'd0, b[2:0]};
            bytes_owed    = PendThree;
         end else begin
            produced         = 1'b1;
            point.code_point = ReplacementChar;
         end
         if (bytes_owed != PendNone && word.last_byte) begin
            // buffer ends right at a lead byte
            produced         = 1'b1;
            point.code_point = ReplacementChar;
            bytes_owed       = PendNone;
            partial_point    = '0;
         end
      end else begin
         partial_point = {partial_point[PointWidth-7:0], b[5:0]};
         bytes_owed    = bytes_owed - 1'b1;
         if (bytes_owed == PendNone) begin
            produced         = 1'b1;
            point.code_point = partial_point;
            partial_point    = '0;
         end else if (word.last_byte) begin
            produced         = 1'b1;
            point.code_point = ReplacementChar;
            bytes_owed       = PendNone;
            partial_point    = '0;
         end
      end
      return produced;
   endfunction

   always @(posedge clock) begin : watch
      out_word_type point;
      out_word_type wanted;
      int           new_errors;
      new_errors = 0;
      if (reset) begin
         bytes_owed    = PendNone;
         partial_point = '0;
         expected_points.delete();
         error_count    <= 0;
         awaiting_count <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            if (decode_byte(req_data, point))
               expected_points.push_back(point);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_points.size() == 0) begin
               new_errors++;
               $display("%0t: unexpected word, expected none, got %h/%b", $time,
                        rsp_data.code_point, rsp_data.code_last);
            end else begin
               wanted = expected_points.pop_front();
               if (rsp_data.code_point !== wanted.code_point) begin
                  new_errors++;
                  $display("%0t: code_point expected %h, got %h", $time,
                           wanted.code_point, rsp_data.code_point);
               end
               if (rsp_data.code_last !== wanted.code_last) begin
                  new_errors++;
                  $display("%0t: code_last expected %b, got %b", $time,
                           wanted.code_last, rsp_data.code_last);
               end
            end
         end
         error_count    <= error_count + new_errors;
         awaiting_count <= expected_points.size();
      end
   end

endmodule

### sim/utf8_stream_decoder_test.sv
`timescale 1ns / 1ps

module utf8_stream_decoder_test;
   import u8sd_pkg::*;

   localparam int QuietLimit = 2000;
   localparam int HoldCycles = 80;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   in_word_type  req_data  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b1;
   out_word_type rsp_data;
   int           error_count;
   int           awaiting_count;

   int           send_idle_pct = 27;
   int           recv_idle_pct = 74;
   int           bytes_sent    = 0;
   bit           hold_go       = 1'b0;

   utf8_stream_decoder i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   utf8_stream_decoder_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .error_count    (error_count),
      .awaiting_count (awaiting_count)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   task automatic send_word(input logic [7:0] value, input logic tail);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{data_byte: value, last_byte: tail};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bytes_sent++;
   endtask

   function automatic logic pick_last(input bit closing);
      return closing ? ($urandom_range(7) == 0) : ($urandom_range(29) == 0);
   endfunction

   // mostly well-formed sequences, some invalid leads and garbage continuations
   task automatic send_sequence();
      int          kind;
      int          len;
      bit          wild;
      logic [7:0]  r;
      logic [7:0]  lead;
      kind = $urandom_range(99);
      r    = 8'($urandom);
      wild = 1'b0;
      len  = 1;
      if (kind < 15) begin
         lead = {1'b0, r[6:0]};
      end else if (kind < 35) begin
         lead = {3'b110, r[4:0]};
         len  = 2;
      end else if (kind < 55) begin
         lead = {4'b1110, r[3:0]};
         len  = 3;
      end else if (kind < 75) begin
         lead = {5'b11110, r[2:0]};
         len  = 4;
      end else if (kind < 85) begin
         lead = r[7] ? {2'b10, r[5:0]} : {5'b11111, r[2:0]};
      end else if (kind < 93) begin
         wild = 1'b1;
         len  = $urandom_range(4, 2);
         case (len)
            2:       lead = {3'b110, r[4:0]};
            3:       lead = {4'b1110, r[3:0]};
            default: lead = {5'b11110, r[2:0]};
         endcase
      end else begin
         lead = r;
      end
      send_word(lead, pick_last(len == 1));
      for (int i = 1; i < len; i++) begin
         r = 8'($urandom);
         send_word(wild ? r : {2'b10, r[5:0]}, pick_last(i == len - 1));
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (awaiting_count != 0) @(posedge clock);
   endtask

   initial begin
      forever begin
         @(posedge clock);
         if (hold_go) begin
            hold_go = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HoldCycles) @(posedge clock);
         end
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QuietLimit) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet = 0;
         else
            quiet++;
      end
      $display("FAIL");
      $finish;
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      send_word(8'h00, 1'b0);
      send_word(8'h7F, 1'b1);
      send_word(8'hC2, 1'b0);
      send_word(8'hA9, 1'b0);
      send_word(8'hE2, 1'b0);
      send_word(8'h82, 1'b0);
      send_word(8'hAC, 1'b0);
      send_word(8'hF0, 1'b0);
      send_word(8'h9F, 1'b0);
      send_word(8'h98, 1'b0);
      send_word(8'h80, 1'b0);
      send_word(8'hF7, 1'b0);
      send_word(8'hBF, 1'b0);
      send_word(8'hBF, 1'b0);
      send_word(8'hBF, 1'b1);
      send_word(8'h80, 1'b0);   // continuation in lead position
      send_word(8'hFF, 1'b0);
      send_word(8'hF8, 1'b0);
      send_word(8'hE2, 1'b1);   // buffer ends at a lead byte
      send_word(8'hE2, 1'b0);
      send_word(8'h82, 1'b1);   // buffer ends mid-sequence
      send_word(8'hC3, 1'b0);
      send_word(8'h41, 1'b1);   // non-continuation inside a sequence

      while (bytes_sent < 220) send_sequence();
      drain();

      send_idle_pct = 74;
      recv_idle_pct = 27;
      while (bytes_sent < 440) send_sequence();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_go       = 1'b1;
      while (bytes_sent < 670) send_sequence();

      drain();
      repeat (8) @(posedge clock);
      if (error_count == 0 && awaiting_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

### sim.f
sv/u8sd_pkg.sv
sv/u8sd_in_stage.sv
sv/u8sd_decode.sv
sv/u8sd_out_stage.sv
sv/utf8_stream_decoder.sv
sim/utf8_stream_decoder_checker.sv
sim/utf8_stream_decoder_test.sv
